/* rtl/core/pgsd_pkg.sv */
// ----------------------------------------------------------------------------
// pgsd_pkg
// Shared widths, codes and pipeline types for the perfect gas state decoder.
// ----------------------------------------------------------------------------
package pgsd_pkg;

  localparam int WORD_W   = 48;   // signed Q32.16 word
  localparam int RHO_W    = 47;   // unsigned density
  localparam int FRAC_W   = 16;
  localparam int GAMMA_W  = 18;
  localparam int HALF_W   = 24;   // multiplier operand slice
  localparam int KE_W     = 81;
  localparam int EM_W     = 82;
  localparam int RM_W     = 95;
  localparam int PW_W     = 113;
  localparam int GP_W     = 66;
  localparam int DIV_W    = 81;   // dividend / quotient bits, one divider cell each
  localparam int SQ_IN_W  = 82;
  localparam int ROOT_W   = 41;   // root bits, one root cell each
  localparam int SREM_W   = 43;
  localparam int DIMS_W   = 2;
  localparam int STAT_W   = 2;

  localparam logic [GAMMA_W-1:0] GAMMA_ONE   = 18'd65536;
  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 18'd91750;
  localparam logic [DIMS_W-1:0]  DIMS_RESET  = 2'd3;

  localparam logic [WORD_W-1:0] SIGN_MAG = 48'h8000_0000_0000;
  localparam logic [WORD_W-1:0] POS_MAX  = 48'h7FFF_FFFF_FFFF;

  localparam logic CFG_GAMMA = 1'b0;
  localparam logic CFG_DIMS  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_RHO_BAD = 2'd1;
  localparam logic [STAT_W-1:0] ST_P_NEG   = 2'd2;

  typedef struct packed {
    logic [WORD_W-1:0] internal_energy;
    logic [WORD_W-1:0] pressure;
    logic [STAT_W-1:0] status;
  } side_t;

  typedef struct packed {
    logic              valid;
    side_t             side;
    logic [RHO_W-1:0]  rho;
    logic [RHO_W-1:0]  rem;
    logic [DIV_W-1:0]  work;
  } div_t;

  typedef struct packed {
    logic               valid;
    side_t              side;
    logic [SREM_W-1:0]  rem;
    logic [ROOT_W-1:0]  root;
    logic [SQ_IN_W-1:0] work;
  } sqrt_t;

endpackage

/* rtl/core/perfect_gas_state_decode_core.sv */
// ----------------------------------------------------------------------------
// perfect_gas_state_decode_core
// Ideal gas equation of state: e, p and sound speed for one flow cell a beat.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | density, total_energy, velocity_x/y/z
//  out     | out_valid/ out_ready | internal_energy, pressure, sound_speed, status
//  cfg     | cfg_valid/ cfg_ready | cfg_index (0 gamma, 1 dimensions), cfg_data
//
//  One beat a cycle in and out; the path is 9 front stages, 81 divider
//  cells (one quotient bit each), 41 root cells (one root bit each), output reg.
//  The whole chain moves together; it holds while out_valid waits on out_ready.
//  Reset clears the valid bits and loads gamma = 1.4, dimensions = 3.
//  cfg_ready is always high.
module perfect_gas_state_decode_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [pgsd_pkg::RHO_W-1:0]         density,
  input  logic signed [pgsd_pkg::WORD_W-1:0] total_energy,
  input  logic signed [pgsd_pkg::WORD_W-1:0] velocity_x,
  input  logic signed [pgsd_pkg::WORD_W-1:0] velocity_y,
  input  logic signed [pgsd_pkg::WORD_W-1:0] velocity_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [pgsd_pkg::WORD_W-1:0] internal_energy,
  output logic signed [pgsd_pkg::WORD_W-1:0] pressure,
  output logic [pgsd_pkg::RHO_W-1:0]         sound_speed,
  output logic [pgsd_pkg::STAT_W-1:0]        status,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic [pgsd_pkg::GAMMA_W-1:0]       cfg_data
);

  localparam int DW = pgsd_pkg::DIV_W;
  localparam int RT = pgsd_pkg::ROOT_W;

  logic                            adv;
  logic [pgsd_pkg::GAMMA_W-1:0]    gamma;
  logic [pgsd_pkg::DIMS_W-1:0]     dims;
  pgsd_pkg::div_t                  dchain [DW+1];
  pgsd_pkg::sqrt_t                 schain [RT+1];

  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma <= pgsd_pkg::GAMMA_RESET;
      dims  <= pgsd_pkg::DIMS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        pgsd_pkg::CFG_GAMMA: gamma <= cfg_data;
        pgsd_pkg::CFG_DIMS:  dims  <= cfg_data[pgsd_pkg::DIMS_W-1:0];
        default: ;
      endcase
    end
  end

  pgsd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_fire      (in_valid && adv),
    .density      (density),
    .total_energy (total_energy),
    .velocity_x   (velocity_x),
    .velocity_y   (velocity_y),
    .velocity_z   (velocity_z),
    .gamma        (gamma),
    .dims         (dims),
    .dout         (dchain[0])
  );

  for (genvar i = 0; i < DW; i++) begin : g_div
    pgsd_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .din  (dchain[i]),
      .dout (dchain[i+1])
    );
  end

  always_comb begin
    schain[0].valid = dchain[DW].valid;
    schain[0].side  = dchain[DW].side;
    schain[0].rem   = '0;
    schain[0].root  = '0;
    schain[0].work  = pgsd_pkg::SQ_IN_W'(dchain[DW].work);
  end

  for (genvar j = 0; j < RT; j++) begin : g_sqrt
    pgsd_sqrt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .din  (schain[j]),
      .dout (schain[j+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= schain[RT].valid;
    end
  end

  // sound speed only where status is clean
  always_ff @(posedge clk) begin
    if (adv) begin
      internal_energy <= schain[RT].side.internal_energy;
      pressure        <= schain[RT].side.pressure;
      status          <= schain[RT].side.status;
      sound_speed     <= (schain[RT].side.status == pgsd_pkg::ST_OK)
                         ? pgsd_pkg::RHO_W'(schain[RT].root) : '0;
    end
  end

endmodule

/* rtl/core/pgsd_front.sv */
// ----------------------------------------------------------------------------
// pgsd_front
// Nine-stage front end: kinetic, internal energy, pressure and the dividend.
// ----------------------------------------------------------------------------
module pgsd_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               adv,
  input  logic                               in_fire,
  input  logic [pgsd_pkg::RHO_W-1:0]         density,
  input  logic signed [pgsd_pkg::WORD_W-1:0] total_energy,
  input  logic signed [pgsd_pkg::WORD_W-1:0] velocity_x,
  input  logic signed [pgsd_pkg::WORD_W-1:0] velocity_y,
  input  logic signed [pgsd_pkg::WORD_W-1:0] velocity_z,
  input  logic [pgsd_pkg::GAMMA_W-1:0]       gamma,
  input  logic [pgsd_pkg::DIMS_W-1:0]        dims,
  output pgsd_pkg::div_t                     dout
);

  localparam int W  = pgsd_pkg::WORD_W;
  localparam int H  = pgsd_pkg::HALF_W;
  localparam int RW = pgsd_pkg::RHO_W;
  localparam int GW = pgsd_pkg::GAMMA_W;

  logic [8:0] vld;

  // stage 1: velocity magnitudes squared in slices
  logic [W-1:0]   vin [3];
  logic [W-1:0]   vmag [3];
  logic [2*H-1:0] s1_hh [3];
  logic [2*H-1:0] s1_hl [3];
  logic [2*H-1:0] s1_ll [3];
  logic [RW-1:0]  s1_rho;
  logic [W-1:0]   s1_me;
  logic           s1_ne;
  logic           s1_zero;

  always_comb begin
    vin[0] = velocity_x;
    vin[1] = velocity_y;
    vin[2] = velocity_z;
    for (int d = 0; d < 3; d++) begin
      vmag[d] = vin[d][W-1] ? (~vin[d] + 1'b1) : vin[d];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int d = 0; d < 3; d++) begin
        if (dims > 2'(d)) begin
          s1_hh[d] <= vmag[d][W-1:H] * vmag[d][W-1:H];
          s1_hl[d] <= vmag[d][W-1:H] * vmag[d][H-1:0];
          s1_ll[d] <= vmag[d][H-1:0] * vmag[d][H-1:0];
        end else begin
          s1_hh[d] <= '0;
          s1_hl[d] <= '0;
          s1_ll[d] <= '0;
        end
      end
      s1_rho  <= density;
      s1_me   <= total_energy[W-1] ? (~total_energy + 1'b1) : total_energy;
      s1_ne   <= total_energy[W-1];
      s1_zero <= (density == '0);
    end
  end

  // stage 2: ke = sum(v^2) / 2^(F+1)
  logic [97:0]                 ke_full;
  logic [pgsd_pkg::KE_W-1:0]   s2_ke;
  logic [RW-1:0]               s2_rho;
  logic [W-1:0]                s2_me;
  logic                        s2_ne;
  logic                        s2_zero;

  always_comb begin
    ke_full = '0;
    for (int d = 0; d < 3; d++) begin
      ke_full = ke_full + (98'(s1_hh[d]) << 48) + (98'(s1_hl[d]) << 25) + 98'(s1_ll[d]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ke   <= ke_full[97:17];
      s2_rho  <= s1_rho;
      s2_me   <= s1_me;
      s2_ne   <= s1_ne;
      s2_zero <= s1_zero;
    end
  end

  // stage 3: e = E - ke, saturated
  logic [pgsd_pkg::EM_W-1:0] em;
  logic [pgsd_pkg::EM_W-1:0] ke_x;
  logic [pgsd_pkg::EM_W-1:0] me_x;
  logic                      em_neg;
  logic [W-1:0]              em_lim;
  logic [W-1:0]              em_sat;
  logic [W-1:0]              s3_me;
  logic                      s3_ne;
  logic [RW-1:0]             s3_rho;
  logic                      s3_zero;

  always_comb begin
    ke_x = pgsd_pkg::EM_W'(s2_ke);
    me_x = pgsd_pkg::EM_W'(s2_me);
    if (s2_ne) begin
      em     = ke_x + me_x;
      em_neg = 1'b1;
    end else if (ke_x <= me_x) begin
      em     = me_x - ke_x;
      em_neg = 1'b0;
    end else begin
      em     = ke_x - me_x;
      em_neg = 1'b1;
    end
    em_lim = em_neg ? pgsd_pkg::SIGN_MAG : pgsd_pkg::POS_MAX;
    em_sat = (em > pgsd_pkg::EM_W'(em_lim)) ? em_lim : em[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_me   <= em_sat;
      s3_ne   <= em_neg && (em_sat != '0);
      s3_rho  <= s2_rho;
      s3_zero <= s2_zero;
    end
  end

  // stage 4: rho * |e| partial products
  logic [2*H-1:0] s4_p11, s4_p10, s4_p01, s4_p00;
  logic [W-1:0]   s4_ie;
  logic           s4_ne;
  logic           s4_zero;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_p11  <= 48'(s3_rho[RW-1:H] * s3_me[W-1:H]);
      s4_p10  <= 48'(s3_rho[RW-1:H] * s3_me[H-1:0]);
      s4_p01  <= s3_rho[H-1:0] * s3_me[W-1:H];
      s4_p00  <= s3_rho[H-1:0] * s3_me[H-1:0];
      s4_ie   <= s3_ne ? (~s3_me + 1'b1) : s3_me;
      s4_ne   <= s3_ne;
      s4_zero <= s3_zero;
    end
  end

  // stage 5: sum of rho * |e|
  logic [pgsd_pkg::RM_W-1:0] s5_rm;
  logic [W-1:0]              s5_ie;
  logic                      s5_ne;
  logic                      s5_zero;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_rm   <= (95'(s4_p11) << 48) + (95'(s4_p10) << 24) + (95'(s4_p01) << 24)
                 + 95'(s4_p00);
      s5_ie   <= s4_ie;
      s5_ne   <= s4_ne;
      s5_zero <= s4_zero;
    end
  end

  // stage 6: times |gamma - 1|, slice by slice
  logic [GW-1:0]      mg;
  logic               ng;
  logic [H+GW-1:0]    s6_q [4];
  logic [W-1:0]       s6_ie;
  logic               s6_np;
  logic               s6_zero;

  always_comb begin
    ng = (gamma < pgsd_pkg::GAMMA_ONE);
    mg = ng ? (pgsd_pkg::GAMMA_ONE - gamma) : (gamma - pgsd_pkg::GAMMA_ONE);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_q[0] <= s5_rm[23:0] * mg;
      s6_q[1] <= s5_rm[47:24] * mg;
      s6_q[2] <= s5_rm[71:48] * mg;
      s6_q[3] <= 42'(s5_rm[94:72] * mg);
      s6_ie   <= s5_ie;
      s6_np   <= s5_ne ^ ng;
      s6_zero <= s5_zero;
    end
  end

  // stage 7: pressure magnitude, saturated
  localparam int KE_BITS_P = pgsd_pkg::PW_W - 32;
  logic [pgsd_pkg::PW_W-1:0] pw;
  logic [KE_BITS_P-1:0]      pw_sh;
  logic [W-1:0]              p_lim;
  logic [W-1:0]              p_sat;
  logic [W-1:0]              s7_mp;
  logic                      s7_np;
  logic [W-1:0]              s7_ie;
  logic                      s7_zero;

  always_comb begin
    pw = '0;
    for (int k = 0; k < 4; k++) begin
      pw = pw + (113'(s6_q[k]) << (H * k));
    end
    pw_sh = pw[pgsd_pkg::PW_W-1:32];
    p_lim = s6_np ? pgsd_pkg::SIGN_MAG : pgsd_pkg::POS_MAX;
    p_sat = (pw_sh > KE_BITS_P'(p_lim)) ? p_lim : pw_sh[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_mp   <= p_sat;
      s7_np   <= s6_np && (p_sat != '0);
      s7_ie   <= s6_ie;
      s7_zero <= s6_zero;
    end
  end

  // stage 8: gamma * p and result fields
  logic [H+GW-1:0]       s8_gh, s8_gl;
  pgsd_pkg::side_t       s8_side;
  logic [RW-1:0]         s8_rho;
  logic [RW-1:0]         s4_rho, s5_rho, s6_rho, s7_rho;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_rho <= s3_rho;
      s5_rho <= s4_rho;
      s6_rho <= s5_rho;
      s7_rho <= s6_rho;
      s8_rho <= s7_rho;
      s8_gh  <= s7_mp[W-1:H] * gamma;
      s8_gl  <= s7_mp[H-1:0] * gamma;
      if (s7_zero) begin
        s8_side.internal_energy <= '0;
        s8_side.pressure        <= '0;
        s8_side.status          <= pgsd_pkg::ST_RHO_BAD;
      end else begin
        s8_side.internal_energy <= s7_ie;
        s8_side.pressure        <= s7_np ? (~s7_mp + 1'b1) : s7_mp;
        s8_side.status          <= s7_np ? pgsd_pkg::ST_P_NEG : pgsd_pkg::ST_OK;
      end
    end
  end

  // stage 9: dividend = gamma * p * 2^(2F-16)
  logic [pgsd_pkg::GP_W-1:0] gp;

  assign gp = (66'(s8_gh) << H) + 66'(s8_gl);

  always_ff @(posedge clk) begin
    if (adv) begin
      dout.side <= s8_side;
      dout.rho  <= s8_rho;
      dout.rem  <= '0;
      dout.work <= {gp[64:0], 16'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[7:0], in_fire};
    end
  end

  assign dout.valid = vld[8];

endmodule

/* rtl/core/pgsd_div_cell.sv */
// ----------------------------------------------------------------------------
// pgsd_div_cell
// One restoring-division step: shifts in a dividend bit, yields a quotient bit.
// ----------------------------------------------------------------------------
module pgsd_div_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  pgsd_pkg::div_t din,
  output pgsd_pkg::div_t dout
);

  localparam int RW = pgsd_pkg::RHO_W;
  localparam int DW = pgsd_pkg::DIV_W;

  logic [RW:0] rem2;
  logic        ge;
  logic [RW:0] rem_n;

  always_comb begin
    rem2  = {din.rem, din.work[DW-1]};
    ge    = (rem2 >= {1'b0, din.rho});
    rem_n = ge ? (rem2 - {1'b0, din.rho}) : rem2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (adv) begin
      dout.valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dout.side <= din.side;
      dout.rho  <= din.rho;
      dout.rem  <= rem_n[RW-1:0];
      dout.work <= {din.work[DW-2:0], ge};
    end
  end

endmodule

/* rtl/core/pgsd_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// pgsd_sqrt_cell
// One digit-by-digit square root step: two radicand bits in, one root bit out.
// ----------------------------------------------------------------------------
module pgsd_sqrt_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  pgsd_pkg::sqrt_t din,
  output pgsd_pkg::sqrt_t dout
);

  localparam int SW = pgsd_pkg::SREM_W;
  localparam int RT = pgsd_pkg::ROOT_W;
  localparam int QW = pgsd_pkg::SQ_IN_W;

  logic [SW+1:0] rem2;
  logic [SW+1:0] trial;
  logic          ge;
  logic [SW+1:0] rem_n;

  always_comb begin
    rem2  = {din.rem, din.work[QW-1:QW-2]};
    trial = (SW + 2)'({din.root, 2'b01});
    ge    = (rem2 >= trial);
    rem_n = ge ? (rem2 - trial) : rem2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (adv) begin
      dout.valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dout.side <= din.side;
      dout.rem  <= rem_n[SW-1:0];
      dout.root <= {din.root[RT-2:0], ge};
      dout.work <= {din.work[QW-3:0], 2'b00};
    end
  end

endmodule
